### sv/fan_lvl_pkg.sv
// ----------------------------------------------------------------------------
// Fan level controller package
// Widths, register map, averaging constants and level codes.
// ----------------------------------------------------------------------------
package fan_lvl_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int SAMPLE_W   = 19;
    localparam int LIMIT_W    = 18;
    localparam int HYST_W     = 15;
    localparam int DUTY_W     = 20;

    // average: sample << FRAC_BITS plus one guard bit
    localparam int AVG_W      = SAMPLE_W + FRAC_BITS + 1;
    // 77*sfx + 179*avg needs eight more bits and a sign margin
    localparam int ACC_W      = AVG_W + 9;
    // compare domain: limits, bands and differences in fixed point
    localparam int CMP_W      = AVG_W + 2;
    // limit +/- band in millidegrees, signed
    localparam int LIMSUM_W   = LIMIT_W + 2;

    localparam int ALPHA_NUM  = 77;
    localparam int ALPHA_REST = 179;
    localparam int ALPHA_SH   = 8;
    localparam int RISE_LIMIT = 2500;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;
    localparam int ADDR_W      = 5;

    localparam logic [2:0] REG_OFF_LIMIT = 3'd0;
    localparam logic [2:0] REG_LOW_LIMIT = 3'd1;
    localparam logic [2:0] REG_MID_LIMIT = 3'd2;
    localparam logic [2:0] REG_HYST_BAND = 3'd3;
    localparam logic [2:0] REG_DUTY_OFF  = 3'd4;
    localparam logic [2:0] REG_DUTY_LOW  = 3'd5;
    localparam logic [2:0] REG_DUTY_MID  = 3'd6;
    localparam logic [2:0] REG_DUTY_HIGH = 3'd7;

    typedef enum logic [1:0] {
        LVL_OFF  = 2'd0,
        LVL_LOW  = 2'd1,
        LVL_MID  = 2'd2,
        LVL_HIGH = 2'd3
    } fan_level_t;

endpackage

### sv/fan_level_hysteresis_controller_core.sv
// ----------------------------------------------------------------------------
// Fan level hysteresis controller
// Temperature smoothing and four-level fan control with hysteresis.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one temperature sample per word (19-bit signed millidegrees).
//   m_axis: one result word per sample: level, duty, change and boost flags
//           and the integer part of the smoothed temperature.
//   APB:    eight limit and duty registers at byte address 4*index; write
//           them only while no sample is in flight.
// Input acceptance loads the input register; averaging (constant
// multiplies, add, shift) and threshold compares then feed the result
// register, which also updates the average and level state. Throughput
// is one sample per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its word and the
// input register fills; s_axis_tready then drops until the result is taken.
// Reset clears the average, previous average and level (off) and loads the
// default limits and duties; both pipeline stages come up empty.
// ----------------------------------------------------------------------------
module fan_level_hysteresis_controller_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [18:0] temp_sample
    input  logic [fan_lvl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [1:0] fan_level, [21:2] duty_value, [22] level_changed,
    // [23] rapid_rise, [42:24] avg_milli
    output logic [fan_lvl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [fan_lvl_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int FB    = fan_lvl_pkg::FRAC_BITS;
    localparam int SW    = fan_lvl_pkg::SAMPLE_W;
    localparam int AW    = fan_lvl_pkg::AVG_W;
    localparam int CW    = fan_lvl_pkg::ACC_W;
    localparam int MW    = fan_lvl_pkg::CMP_W;
    localparam int LW    = fan_lvl_pkg::LIMIT_W;
    localparam int HW    = fan_lvl_pkg::HYST_W;
    localparam int DW    = fan_lvl_pkg::DUTY_W;
    localparam int SUM_W = fan_lvl_pkg::LIMSUM_W;

    localparam logic signed [CW-1:0] ALPHA_N = CW'(fan_lvl_pkg::ALPHA_NUM);
    localparam logic signed [CW-1:0] ALPHA_R = CW'(fan_lvl_pkg::ALPHA_REST);
    localparam logic signed [AW-1:0] ONE_FX  = AW'(1) <<< FB;
    localparam logic signed [MW-1:0] RISE_FX = MW'(fan_lvl_pkg::RISE_LIMIT) <<< FB;

    // millidegree value (signed) to fixed point in the compare domain
    function automatic logic signed [MW-1:0] to_fx(input logic signed [SUM_W-1:0] v);
        logic signed [MW-1:0] ext;
        ext = MW'(v);
        return ext <<< FB;
    endfunction

    // configuration registers
    logic [LW-1:0] off_limit_reg, low_limit_reg, mid_limit_reg;
    logic [HW-1:0] hyst_band_reg;
    logic [DW-1:0] duty_off_reg, duty_low_reg, duty_mid_reg, duty_high_reg;

    logic          cfg_wr;
    logic [2:0]    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_limit_reg <= LW'(45000);
            low_limit_reg <= LW'(55000);
            mid_limit_reg <= LW'(65000);
            hyst_band_reg <= HW'(2000);
            duty_off_reg  <= DW'(0);
            duty_low_reg  <= DW'(15000);
            duty_mid_reg  <= DW'(25000);
            duty_high_reg <= DW'(40000);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                fan_lvl_pkg::REG_OFF_LIMIT: off_limit_reg <= pwdata[LW-1:0];
                fan_lvl_pkg::REG_LOW_LIMIT: low_limit_reg <= pwdata[LW-1:0];
                fan_lvl_pkg::REG_MID_LIMIT: mid_limit_reg <= pwdata[LW-1:0];
                fan_lvl_pkg::REG_HYST_BAND: hyst_band_reg <= pwdata[HW-1:0];
                fan_lvl_pkg::REG_DUTY_OFF:  duty_off_reg  <= pwdata[DW-1:0];
                fan_lvl_pkg::REG_DUTY_LOW:  duty_low_reg  <= pwdata[DW-1:0];
                fan_lvl_pkg::REG_DUTY_MID:  duty_mid_reg  <= pwdata[DW-1:0];
                fan_lvl_pkg::REG_DUTY_HIGH: duty_high_reg <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            fan_lvl_pkg::REG_OFF_LIMIT: prdata = 32'(off_limit_reg);
            fan_lvl_pkg::REG_LOW_LIMIT: prdata = 32'(low_limit_reg);
            fan_lvl_pkg::REG_MID_LIMIT: prdata = 32'(mid_limit_reg);
            fan_lvl_pkg::REG_HYST_BAND: prdata = 32'(hyst_band_reg);
            fan_lvl_pkg::REG_DUTY_OFF:  prdata = 32'(duty_off_reg);
            fan_lvl_pkg::REG_DUTY_LOW:  prdata = 32'(duty_low_reg);
            fan_lvl_pkg::REG_DUTY_MID:  prdata = 32'(duty_mid_reg);
            fan_lvl_pkg::REG_DUTY_HIGH: prdata = 32'(duty_high_reg);
            default:                    prdata = '0;
        endcase
    end

    // pipeline control
    logic          in_valid_reg;
    logic [SW-1:0] in_sample_reg;
    logic          out_valid_reg;
    logic          advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_sample_reg <= s_axis_tdata[SW-1:0];
        end
    end

    // averaging
    logic signed [AW-1:0] avg_reg, prev_reg;
    fan_lvl_pkg::fan_level_t level_reg;

    logic signed [AW-1:0] sfx;
    logic signed [CW-1:0] acc;
    logic                 seed;
    logic signed [AW-1:0] avg_next;
    logic signed [AW-1:0] prev_eff;

    assign sfx  = AW'(signed'(in_sample_reg)) <<< FB;
    assign seed = avg_reg < ONE_FX;
    assign acc  = ALPHA_N * CW'(sfx) + ALPHA_R * CW'(avg_reg);

    always_comb
    begin
        if (seed)
        begin
            avg_next = sfx;
            prev_eff = sfx;
        end
        else
        begin
            // floor division by 256
            avg_next = acc[AW+fan_lvl_pkg::ALPHA_SH-1:fan_lvl_pkg::ALPHA_SH];
            prev_eff = prev_reg;
        end
    end

    // thresholds
    logic signed [SUM_W-1:0] off_m, low_m, mid_m, hyst_m;
    logic signed [MW-1:0]    avg_c, rise_diff;
    logic                    ge_off_up, ge_low_up, ge_mid_up;
    logic                    le_off_dn, le_low_dn, le_mid_dn;
    logic                    below_off, rise;
    fan_lvl_pkg::fan_level_t hyst_level, level_next;
    logic [DW-1:0]           duty_next;

    assign off_m  = SUM_W'(off_limit_reg);
    assign low_m  = SUM_W'(low_limit_reg);
    assign mid_m  = SUM_W'(mid_limit_reg);
    assign hyst_m = SUM_W'(hyst_band_reg);

    assign avg_c     = MW'(avg_next);
    assign rise_diff = MW'(avg_next) - MW'(prev_eff);

    assign below_off = avg_c < to_fx(off_m);
    assign rise      = rise_diff > RISE_FX;
    assign ge_off_up = avg_c >= to_fx(off_m + hyst_m);
    assign ge_low_up = avg_c >= to_fx(low_m + hyst_m);
    assign ge_mid_up = avg_c >= to_fx(mid_m + hyst_m);
    assign le_off_dn = avg_c <= to_fx(off_m - hyst_m);
    assign le_low_dn = avg_c <= to_fx(low_m - hyst_m);
    assign le_mid_dn = avg_c <= to_fx(mid_m - hyst_m);

    always_comb
    begin
        hyst_level = level_reg;
        unique case (level_reg)
            fan_lvl_pkg::LVL_OFF:
            begin
                if (ge_off_up)
                    hyst_level = fan_lvl_pkg::LVL_LOW;
            end
            fan_lvl_pkg::LVL_LOW:
            begin
                if (ge_low_up)
                    hyst_level = fan_lvl_pkg::LVL_MID;
                else if (le_off_dn)
                    hyst_level = fan_lvl_pkg::LVL_OFF;
            end
            fan_lvl_pkg::LVL_MID:
            begin
                if (ge_mid_up)
                    hyst_level = fan_lvl_pkg::LVL_HIGH;
                else if (le_low_dn)
                    hyst_level = fan_lvl_pkg::LVL_LOW;
            end
            fan_lvl_pkg::LVL_HIGH:
            begin
                if (le_mid_dn)
                    hyst_level = fan_lvl_pkg::LVL_MID;
            end
            default: hyst_level = level_reg;
        endcase
    end

    always_comb
    begin
        priority if (below_off)
            level_next = fan_lvl_pkg::LVL_OFF;
        else if (rise)
            level_next = fan_lvl_pkg::LVL_HIGH;
        else
            level_next = hyst_level;
    end

    always_comb
    begin
        unique case (level_next)
            fan_lvl_pkg::LVL_OFF:  duty_next = duty_off_reg;
            fan_lvl_pkg::LVL_LOW:  duty_next = duty_low_reg;
            fan_lvl_pkg::LVL_MID:  duty_next = duty_mid_reg;
            fan_lvl_pkg::LVL_HIGH: duty_next = duty_high_reg;
            default:               duty_next = duty_off_reg;
        endcase
    end

    // state and result word
    logic [fan_lvl_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [fan_lvl_pkg::OUT_TDATA_W-1:0] out_data_next;

    assign out_data_next = {
        5'b0,
        avg_next[SW+FB-1:FB],
        !below_off && rise,
        level_next != level_reg,
        duty_next,
        level_next
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg       <= '0;
            prev_reg      <= '0;
            level_reg     <= fan_lvl_pkg::LVL_OFF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                avg_reg   <= avg_next;
                prev_reg  <= avg_next;
                level_reg <= level_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tdata = out_data_reg;

endmodule
